// ===== rtl/core/dta_pkg.sv =====
`timescale 1ns / 1ps

package dta_pkg;

	localparam int DESCRIPTORS_DEF  = 1024;
	localparam int FILE_ID_BITS_DEF = 16;

	localparam int ROW_BITS  = 32;
	localparam int ROW_SHIFT = 5;

	localparam int OPCODE_W  = 3;
	localparam int FILE_ID_W = 16;
	localparam int FD_W      = 10;
	localparam int KIND_W    = 2;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_OPEN  = 3'd0,
		OP_DUP   = 3'd1,
		OP_DUP2  = 3'd2,
		OP_CLOSE = 3'd3,
		OP_QUERY = 3'd4
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_QUERY = 2'd1,
		KIND_FULL  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	function automatic logic [ROW_SHIFT-1:0] lowest_zero(input logic [ROW_BITS-1:0] row);
		logic [ROW_SHIFT-1:0] idx;
		idx = '0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (!row[i]) begin
				idx = ROW_SHIFT'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== rtl/core/dta_bind_mem.sv =====
`timescale 1ns / 1ps

module dta_bind_mem import dta_pkg::*; #(
	parameter int DESCRIPTORS  = DESCRIPTORS_DEF,
	parameter int FILE_ID_BITS = FILE_ID_BITS_DEF,
	localparam int DESC_BITS   = $clog2(DESCRIPTORS)
) (
	input  logic                    clk,
	input  logic                    rd_en,
	input  logic [DESC_BITS-1:0]    rd_idx,
	output logic                    rd_vld,
	output logic [FILE_ID_BITS-1:0] rd_file,
	input  logic                    wr_en,
	input  logic [DESC_BITS-1:0]    wr_idx,
	input  logic                    wr_vld,
	input  logic [FILE_ID_BITS-1:0] wr_file
);

	logic [FILE_ID_BITS:0] mem [DESCRIPTORS];
	logic [FILE_ID_BITS:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= {wr_vld, wr_file};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_idx];
		end
	end

	assign rd_vld  = rd_q[FILE_ID_BITS];
	assign rd_file = rd_q[FILE_ID_BITS-1:0];

endmodule

// ===== rtl/core/dta_use_map.sv =====
`timescale 1ns / 1ps

module dta_use_map import dta_pkg::*; #(
	parameter int DESCRIPTORS  = DESCRIPTORS_DEF,
	localparam int ROWS        = (DESCRIPTORS + ROW_BITS - 1) / ROW_BITS,
	localparam int ROW_IDX_W   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [ROW_IDX_W-1:0] rd_row,
	output logic [ROW_BITS-1:0]  rd_data,
	output logic [ROW_IDX_W-1:0] free_row,
	output logic                 any_free,
	input  logic                 clr_en,
	input  logic [ROW_IDX_W-1:0] clr_row,
	input  logic                 wr_en,
	input  logic [ROW_IDX_W-1:0] wr_row,
	input  logic [ROW_BITS-1:0]  wr_data
);

	logic [ROW_BITS-1:0] rows_mem [ROWS];
	logic [ROW_BITS-1:0] rd_q;
	logic [ROWS-1:0]     has_free_q;
	logic [ROW_BITS-1:0] init_mask;

	// bits past the last descriptor read as taken
	always_comb begin
		for (int b = 0; b < ROW_BITS; b++) begin
			init_mask[b] = ((32'(clr_row) << ROW_SHIFT) + 32'(b)) >= 32'(DESCRIPTORS);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_en) begin
			rows_mem[clr_row] <= init_mask;
		end else if (wr_en) begin
			rows_mem[wr_row] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= rows_mem[rd_row];
		end
	end

	assign rd_data = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_free_q <= '1;
		end else if (wr_en && !clr_en) begin
			has_free_q[wr_row] <= ~&wr_data;
		end
	end

	always_comb begin
		free_row = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (has_free_q[i]) begin
				free_row = ROW_IDX_W'(i);
			end
		end
		any_free = |has_free_q;
	end

endmodule

// ===== rtl/core/descriptor_table_allocator.sv =====
`timescale 1ns / 1ps
// Order: the command beat is taken in ST_IDLE; any result beat is registered as
// ST_EXEC is left. Each command does a row/binding memory read, then a
// read-modify-write of the same row and a binding entry write, and no new command
// is taken in between; ST_EXEC is held while an earlier result beat still waits
// on m_axis_tready. Reset: clears control state, then a clearing pass in ST_CLEAR
// sweeps both memories; no command is taken until it ends.

module descriptor_table_allocator import dta_pkg::*; #(
	parameter int DESCRIPTORS  = DESCRIPTORS_DEF,
	parameter int FILE_ID_BITS = FILE_ID_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // file_id, source_fd, target_fd, zero pad
	input  logic [OPCODE_W-1:0]  s_axis_tuser,  // opcode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // descriptor, bound_file, zero pad
	output logic [KIND_W-1:0]    m_axis_tuser   // result_kind
);

	localparam int DESC_BITS = $clog2(DESCRIPTORS);
	localparam int ROWS      = (DESCRIPTORS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [DESC_BITS-1:0] LAST_IDX = DESC_BITS'(DESCRIPTORS - 1);

	state_t state_q;
	logic [DESC_BITS-1:0] clr_cnt_q;

	op_t                     op_s1;
	logic [FILE_ID_BITS-1:0] fid_s1;
	logic [DESC_BITS-1:0]    src_idx_s1;
	logic [DESC_BITS-1:0]    dst_idx_s1;
	logic                    src_ok_s1;
	logic                    dst_ok_s1;
	logic [ROW_IDX_W-1:0]    row_s1;
	logic [ROW_SHIFT-1:0]    bit_s1;
	logic                    full_s1;

	logic                  out_vld_q;
	kind_t                 out_kind_q;
	logic [FD_W-1:0]       out_desc_q;
	logic [FILE_ID_W-1:0]  out_file_q;

	logic                 accept;
	op_t                  in_op;
	logic [31:0]          src32;
	logic [31:0]          dst32;
	logic                 src_ok;
	logic                 dst_ok;
	logic [ROW_IDX_W-1:0] rd_row;
	logic [ROW_SHIFT-1:0] in_bit;

	logic [ROW_IDX_W-1:0] free_row;
	logic                 any_free;
	logic [ROW_BITS-1:0]  row_data;
	logic                 bind_vld_raw;
	logic [FILE_ID_BITS-1:0] bind_file;

	logic                    go;
	logic                    bind_vld;
	logic [ROW_SHIFT-1:0]    free_bit;
	logic [31:0]             slot32;
	logic                    use_wr;
	logic [ROW_BITS-1:0]     use_wdata;
	logic                    bind_wr;
	logic [DESC_BITS-1:0]    bind_widx;
	logic                    bind_wvld;
	logic [FILE_ID_BITS-1:0] bind_wfile;
	logic                    emit;
	kind_t                   emit_kind;
	logic [FD_W-1:0]         emit_desc;
	logic [FILE_ID_W-1:0]    emit_file;

	logic                    clr_on;
	logic [31:0]             clr32;
	logic                    mem_bind_wr;
	logic [DESC_BITS-1:0]    mem_bind_widx;
	logic                    mem_bind_wvld;
	logic [FILE_ID_BITS-1:0] mem_bind_wfile;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_op         = op_t'(s_axis_tuser);
	assign src32         = 32'(s_axis_tdata[25:16]);
	assign dst32         = 32'(s_axis_tdata[35:26]);
	assign src_ok        = src32 < 32'(DESCRIPTORS);
	assign dst_ok        = dst32 < 32'(DESCRIPTORS);

	always_comb begin
		rd_row = ROW_IDX_W'(src32 >> ROW_SHIFT);
		in_bit = src32[ROW_SHIFT-1:0];
		case (in_op)
			OP_OPEN, OP_DUP: begin
				rd_row = free_row;
			end
			OP_DUP2: begin
				rd_row = ROW_IDX_W'(dst32 >> ROW_SHIFT);
				in_bit = dst32[ROW_SHIFT-1:0];
			end
			default: begin
			end
		endcase
	end

	assign clr_on = (state_q == ST_CLEAR);
	assign clr32  = 32'(clr_cnt_q);

	dta_use_map #(
		.DESCRIPTORS(DESCRIPTORS)
	) u_use_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_row  (rd_row),
		.rd_data (row_data),
		.free_row(free_row),
		.any_free(any_free),
		.clr_en  (clr_on && (clr32[ROW_SHIFT-1:0] == '0)),
		.clr_row (ROW_IDX_W'(clr32 >> ROW_SHIFT)),
		.wr_en   (use_wr),
		.wr_row  (row_s1),
		.wr_data (use_wdata)
	);

	assign mem_bind_wr    = clr_on || bind_wr;
	assign mem_bind_widx  = clr_on ? clr_cnt_q : bind_widx;
	assign mem_bind_wvld  = clr_on ? 1'b0 : bind_wvld;
	assign mem_bind_wfile = clr_on ? '0 : bind_wfile;

	dta_bind_mem #(
		.DESCRIPTORS (DESCRIPTORS),
		.FILE_ID_BITS(FILE_ID_BITS)
	) u_bind_mem (
		.clk    (clk),
		.rd_en  (accept),
		.rd_idx (DESC_BITS'(src32)),
		.rd_vld (bind_vld_raw),
		.rd_file(bind_file),
		.wr_en  (mem_bind_wr),
		.wr_idx (mem_bind_widx),
		.wr_vld (mem_bind_wvld),
		.wr_file(mem_bind_wfile)
	);

	assign go       = (state_q == ST_EXEC) && (!out_vld_q || m_axis_tready);
	assign bind_vld = bind_vld_raw && src_ok_s1;
	assign free_bit = lowest_zero(row_data);
	assign slot32   = (32'(row_s1) << ROW_SHIFT) | 32'(free_bit);

	always_comb begin
		use_wr     = 1'b0;
		use_wdata  = row_data;
		bind_wr    = 1'b0;
		bind_widx  = DESC_BITS'(slot32);
		bind_wvld  = 1'b0;
		bind_wfile = '0;
		emit       = 1'b0;
		emit_kind  = KIND_ALLOC;
		emit_desc  = '0;
		emit_file  = '0;
		case (op_s1)
			OP_OPEN, OP_DUP: begin
				emit = 1'b1;
				if (full_s1) begin
					emit_kind = KIND_FULL;
				end else begin
					use_wr              = 1'b1;
					use_wdata[free_bit] = 1'b1;
					bind_wr             = 1'b1;
					bind_wvld           = (op_s1 == OP_OPEN) ? 1'b1 : bind_vld;
					bind_wfile          = (op_s1 == OP_OPEN) ? fid_s1 : bind_file;
					emit_desc           = FD_W'(slot32);
				end
			end
			OP_DUP2: begin
				if (dst_ok_s1) begin
					use_wr            = 1'b1;
					use_wdata[bit_s1] = 1'b1;
					bind_wr           = 1'b1;
					bind_widx         = dst_idx_s1;
					bind_wvld         = bind_vld;
					bind_wfile        = bind_file;
				end
			end
			OP_CLOSE: begin
				if (src_ok_s1) begin
					use_wr            = 1'b1;
					use_wdata[bit_s1] = 1'b0;
					bind_wr           = 1'b1;
					bind_widx         = src_idx_s1;
				end
			end
			OP_QUERY: begin
				if (bind_vld) begin
					emit      = 1'b1;
					emit_kind = KIND_QUERY;
					emit_file = FILE_ID_W'(32'(bind_file));
				end
			end
			default: begin
			end
		endcase
		if (!go) begin
			use_wr  = 1'b0;
			bind_wr = 1'b0;
			emit    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + DESC_BITS'(1);
					if (clr_cnt_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= in_op;
			fid_s1     <= FILE_ID_BITS'(32'(s_axis_tdata[15:0]));
			src_idx_s1 <= DESC_BITS'(src32);
			dst_idx_s1 <= DESC_BITS'(dst32);
			src_ok_s1  <= src_ok;
			dst_ok_s1  <= dst_ok;
			row_s1     <= rd_row;
			bit_s1     <= in_bit;
			full_s1    <= !any_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= emit_kind;
			out_desc_q <= emit_desc;
			out_file_q <= emit_file;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tdata  = {{(M_TDATA_W - FD_W - FILE_ID_W){1'b0}}, out_file_q, out_desc_q};

endmodule

// ===== verif/dta_checker.sv =====
`timescale 1ns / 1ps

module dta_checker import dta_pkg::*; #(
	parameter int DESCRIPTORS = DESCRIPTORS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // file_id, source_fd, target_fd, zero pad
	input  logic [OPCODE_W-1:0]  s_axis_tuser,  // opcode
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [M_TDATA_W-1:0] m_axis_tdata,  // descriptor, bound_file, zero pad
	input  logic [KIND_W-1:0]    m_axis_tuser,  // result_kind
	output int                   mismatches,
	output int                   pending
);

	typedef struct packed {
		kind_t                kind;
		logic [FD_W-1:0]      descriptor;
		logic [FILE_ID_W-1:0] bound_file;
	} fd_result_t;

	bit                   in_use   [DESCRIPTORS];
	bit                   bound    [DESCRIPTORS];
	logic [FILE_ID_W-1:0] file_of  [DESCRIPTORS];
	fd_result_t           awaited_results[$];

	function automatic bit apply_command(input logic [OPCODE_W-1:0] code,
			input logic [FILE_ID_W-1:0] fid, input int src, input int dst,
			output fd_result_t res);
		int                   slot;
		bit                   src_bound;
		logic [FILE_ID_W-1:0] src_file;
		res = '{kind: KIND_ALLOC, descriptor: '0, bound_file: '0};
		slot = -1;
		for (int i = 0; i < DESCRIPTORS; i++) begin
			if (!in_use[i]) begin
				slot = i;
				break;
			end
		end
		src_bound = 1'b0;
		src_file = '0;
		if (src < DESCRIPTORS && bound[src]) begin
			src_bound = 1'b1;
			src_file = file_of[src];
		end
		case (code)
			OP_OPEN, OP_DUP: begin
				if (slot < 0) begin
					res.kind = KIND_FULL;
					return 1'b1;
				end
				in_use[slot] = 1'b1;
				bound[slot] = (code == OP_OPEN) ? 1'b1 : src_bound;
				file_of[slot] = (code == OP_OPEN) ? fid : src_file;
				res.descriptor = FD_W'(slot);
				return 1'b1;
			end
			OP_DUP2: begin
				if (dst < DESCRIPTORS) begin
					bound[dst] = src_bound;
					file_of[dst] = src_file;
					in_use[dst] = 1'b1;
				end
				return 1'b0;
			end
			OP_CLOSE: begin
				if (src < DESCRIPTORS) begin
					in_use[src] = 1'b0;
					bound[src] = 1'b0;
					file_of[src] = '0;
				end
				return 1'b0;
			end
			OP_QUERY: begin
				if (!src_bound)
					return 1'b0;
				res.kind = KIND_QUERY;
				res.bound_file = src_file;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fd_result_t got, want, res;
		if (!arst_n) begin
			for (int i = 0; i < DESCRIPTORS; i++) begin
				in_use[i] = 1'b0;
				bound[i] = 1'b0;
				file_of[i] = '0;
			end
			awaited_results.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = kind_t'(m_axis_tuser);
				got.descriptor = m_axis_tdata[FD_W-1:0];
				got.bound_file = m_axis_tdata[FD_W +: FILE_ID_W];
				if (awaited_results.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected result beat: kind %0d desc %0d file %h",
							$time, got.kind, got.descriptor, got.bound_file);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display({"%0t: result mismatch: expected kind %0d desc %0d file %h,",
								" got kind %0d desc %0d file %h"}, $time, want.kind,
								want.descriptor, want.bound_file, got.kind, got.descriptor,
								got.bound_file);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (apply_command(s_axis_tuser, s_axis_tdata[FILE_ID_W-1:0],
						int'(s_axis_tdata[FILE_ID_W +: FD_W]),
						int'(s_axis_tdata[FILE_ID_W+FD_W +: FD_W]), res))
					awaited_results.insert(awaited_results.size(), res);
			end
			pending = awaited_results.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import dta_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int MAX_FD         = DESCRIPTORS_DEF - 1;
	localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
	logic [OPCODE_W-1:0]  s_axis_tuser  = OP_OPEN;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [KIND_W-1:0]    m_axis_tuser;

	int mismatches;
	int pending;
	int idle_cycles = 0;
	int sent        = 0;
	bit sender_calm = 1'b0;
	bit hold_req    = 1'b0;
	bit hold_done   = 1'b0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	descriptor_table_allocator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	dta_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("descriptor_table_allocator verification failed");
			$finish;
		end
	end

	task automatic send_command(input logic [OPCODE_W-1:0] code,
			input logic [FILE_ID_W-1:0] fid, input logic [FD_W-1:0] src,
			input logic [FD_W-1:0] dst);
		int gap;
		if (sent % 40 == 0)
			sender_calm = ($urandom_range(0, 2) == 0);
		gap = sender_calm ? 0 : $urandom_range(0, 14);
		sent++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(S_TDATA_W - 2 * FD_W - FILE_ID_W){1'b0}}, dst, src, fid};
		s_axis_tuser <= code;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// weights in percent; the remainder goes to unused opcodes
	task automatic random_command(input int w_open, input int w_dup, input int w_dup2,
			input int w_close, input int w_query, input int fd_hi);
		int                  pick;
		logic [OPCODE_W-1:0] code;
		logic [FD_W-1:0]     src;
		logic [FD_W-1:0]     dst;
		pick = $urandom_range(0, 99);
		if (pick < w_open)
			code = OP_OPEN;
		else if (pick < w_open + w_dup)
			code = OP_DUP;
		else if (pick < w_open + w_dup + w_dup2)
			code = OP_DUP2;
		else if (pick < w_open + w_dup + w_dup2 + w_close)
			code = OP_CLOSE;
		else if (pick < w_open + w_dup + w_dup2 + w_close + w_query)
			code = OP_QUERY;
		else
			code = OPCODE_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		src = ($urandom_range(0, 4) == 0) ? FD_W'($urandom_range(0, MAX_FD))
			: FD_W'($urandom_range(0, fd_hi));
		dst = ($urandom_range(0, 4) == 0) ? FD_W'($urandom_range(0, MAX_FD))
			: FD_W'($urandom_range(0, fd_hi));
		send_command(code, FILE_ID_W'($urandom), src, dst);
	endtask

	initial begin
		int  gap;
		int  taken;
		bit  calm;
		taken = 0;
		calm = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			if (taken % 40 == 0)
				calm = ($urandom_range(0, 2) == 0);
			gap = calm ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			taken++;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(OP_QUERY, FILE_ID_W'($urandom), 10'd0, FD_W'($urandom));
		send_command(OP_OPEN, 16'hFFFF, FD_W'($urandom), FD_W'($urandom));
		send_command(OP_OPEN, 16'h0000, FD_W'($urandom), FD_W'($urandom));
		send_command(OP_QUERY, FILE_ID_W'($urandom), 10'd0, FD_W'($urandom));
		send_command(OP_QUERY, FILE_ID_W'($urandom), 10'd1, FD_W'($urandom));
		send_command(OP_DUP, FILE_ID_W'($urandom), 10'd0, FD_W'($urandom));
		send_command(OP_DUP, FILE_ID_W'($urandom), 10'd1023, FD_W'($urandom));
		send_command(OP_QUERY, FILE_ID_W'($urandom), 10'd3, FD_W'($urandom));
		send_command(OP_DUP2, FILE_ID_W'($urandom), 10'd0, 10'd1023);
		send_command(OP_QUERY, FILE_ID_W'($urandom), 10'd1023, FD_W'($urandom));
		send_command(OP_DUP2, FILE_ID_W'($urandom), 10'd1023, 10'd1023);
		send_command(OP_QUERY, FILE_ID_W'($urandom), 10'd1023, FD_W'($urandom));
		send_command(OP_DUP2, FILE_ID_W'($urandom), 10'd5, 10'd2);
		send_command(OP_QUERY, FILE_ID_W'($urandom), 10'd2, FD_W'($urandom));
		send_command(OP_CLOSE, FILE_ID_W'($urandom), 10'd1, FD_W'($urandom));
		send_command(OP_OPEN, 16'hA5A5, FD_W'($urandom), FD_W'($urandom));
		send_command(OP_CLOSE, FILE_ID_W'($urandom), 10'd1023, FD_W'($urandom));
		send_command(OP_QUERY, FILE_ID_W'($urandom), 10'd1023, FD_W'($urandom));
		for (int code = OP_UNUSED_FIRST; code <= OP_UNUSED_LAST; code++)
			send_command(OPCODE_W'(code), FILE_ID_W'($urandom), FD_W'($urandom),
				FD_W'($urandom));
		send_command(OP_CLOSE, FILE_ID_W'($urandom), 10'd0, FD_W'($urandom));
		send_command(OP_DUP, FILE_ID_W'($urandom), 10'd3, FD_W'($urandom));
		send_command(OP_QUERY, FILE_ID_W'($urandom), 10'd0, FD_W'($urandom));

		// churn in the low descriptors
		repeat (400) random_command(25, 15, 15, 25, 15, 31);
		// fill the table until it reports full, with the sink stalled for a while
		hold_req = 1'b1;
		repeat (1150) random_command(75, 18, 0, 0, 7, MAX_FD);
		repeat (250) random_command(10, 10, 10, 55, 15, MAX_FD);
		s_axis_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("descriptor_table_allocator verification clean");
		else
			$display("descriptor_table_allocator verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/dta_pkg.sv
rtl/core/dta_bind_mem.sv
rtl/core/dta_use_map.sv
rtl/core/descriptor_table_allocator.sv
verif/dta_checker.sv
verif/tb_top.sv
